[rtl/tccs_pkg.sv]
// Shared types, constants and helpers for the text console cursor/scroll engine.
`timescale 1ns / 1ps

package tccs_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_SUM_W = ROW_W + 1;

    // Word field widths
    localparam int OP_W        = 1;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int CELL_W      = CHAR_W + COLOR_W;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    // Config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOR = '0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0]  CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0]  CH_BLANK    = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0]  BLANK_CELL  = {RESET_COLOR, CH_BLANK};

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [CHAR_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [COL_FIELD_W-1:0] read_col;
    } cmd_word_t;

    typedef struct packed {
        logic [COLOR_W-1:0] text_color;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_BLANK,
        ST_RESP
    } state_t;

    // Logical row plus ring base, folded back into 0..ROWS-1
    function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W-1:0] a,
                                                  input logic [ROW_W-1:0] b);
        logic [ROW_SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ROW_SUM_W'(ROWS))
            s = s - ROW_SUM_W'(ROWS);
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

[rtl/tccs_cmd_if.sv]
// Command channel: valid/ready plus the command word fields.
`timescale 1ns / 1ps

interface tccs_cmd_if import tccs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_col;

    modport source (output valid, output op, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input op, input char_code, input read_row,
                    input read_col, output ready);
endinterface

[rtl/tccs_rsp_if.sv]
// Response channel: valid/ready plus the result word fields.
`timescale 1ns / 1ps

interface tccs_rsp_if import tccs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CELL_W-1:0]      cell_value;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_col;
    logic                   scrolled;

    modport source (output valid, output cell_value, output cursor_row,
                    output cursor_col, output scrolled, input ready);
    modport sink   (input valid, input cell_value, input cursor_row,
                    input cursor_col, input scrolled, output ready);
endinterface

[rtl/tccs_ram.sv]
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tccs_apb.sv]
// APB configuration register block (text color attribute).
`timescale 1ns / 1ps

module tccs_apb import tccs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [COLOR_W-1:0]   text_color_reg;
    logic [COLOR_W-1:0]   text_color_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_TEXT_COLOR);

    always_comb
    begin
        text_color_next = text_color_reg;
        if (wr_en)
            text_color_next = pwdata[COLOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_color_reg <= RESET_COLOR;
        else
            text_color_reg <= text_color_next;
    end

    assign prdata         = (reg_idx == REG_TEXT_COLOR) ? APB_DATA_W'(text_color_reg) : '0;
    assign cfg.text_color = text_color_reg;

endmodule

[rtl/tccs_core.sv]
// Console sequencer: screen RAM, cursor, scroll ring base and result register.
`timescale 1ns / 1ps

module tccs_core import tccs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    tccs_cmd_if.sink   cmd,
    tccs_rsp_if.source rsp
);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    cmd_word_t          item_reg, item_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   base_reg, base_next;
    logic [ROW_W-1:0]   blank_row_reg, blank_row_next;
    logic [COL_W-1:0]   blank_col_reg, blank_col_next;
    logic [CELL_W-1:0]  cell_reg, cell_next;
    logic               scrolled_reg, scrolled_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic [CELL_W-1:0]      rsp_cell_reg, rsp_cell_next;
    logic [ROW_FIELD_W-1:0] rsp_row_reg, rsp_row_next;
    logic [COL_FIELD_W-1:0] rsp_col_reg, rsp_col_next;
    logic                   rsp_scr_reg, rsp_scr_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    logic             is_read, is_lf, is_cr, last_row, last_col;
    logic             advance, do_scroll, rd_in_range, out_free;
    logic             clr_done, blank_done;
    logic [ROW_W-1:0] cur_phys, rd_phys;

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Item decode
    assign is_read     = (item_reg.op == OP_READ);
    assign is_lf       = (item_reg.char_code == CH_LF);
    assign is_cr       = (item_reg.char_code == CH_CR);
    assign last_row    = (cur_row_reg == ROW_W'(ROWS - 1));
    assign last_col    = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign advance     = !is_read && (is_lf || (!is_cr && last_col));
    assign do_scroll   = advance && last_row;
    assign rd_in_range = (int'(item_reg.read_row) < ROWS) && (int'(item_reg.read_col) < COLUMNS);
    assign cur_phys    = row_wrap(cur_row_reg, base_reg);
    assign rd_phys     = row_wrap(ROW_W'(item_reg.read_row), base_reg);
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign clr_done    = (clr_cnt_reg == ADDR_W'(CELLS - 1));
    assign blank_done  = (blank_col_reg == COL_W'(COLUMNS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                priority if (is_read && rd_in_range)
                    state_next = ST_READ;
                else if (do_scroll)
                    state_next = ST_BLANK;
                else
                    state_next = ST_RESP;
            end
            ST_READ:
                state_next = ST_RESP;
            ST_BLANK:
            begin
                if (blank_done)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory port and result register
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        base_next      = base_reg;
        blank_row_next = blank_row_reg;
        blank_col_next = blank_col_reg;
        cell_next      = cell_reg;
        scrolled_next  = scrolled_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_cell_next  = rsp_cell_reg;
        rsp_row_next   = rsp_row_reg;
        rsp_col_next   = rsp_col_reg;
        rsp_scr_next   = rsp_scr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = BLANK_CELL;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    item_next.op        = cmd.op;
                    item_next.char_code = cmd.char_code;
                    item_next.read_row  = cmd.read_row;
                    item_next.read_col  = cmd.read_col;
                end
            end
            ST_EXEC:
            begin
                cell_next     = '0;
                scrolled_next = 1'b0;
                if (is_read)
                begin
                    if (rd_in_range)
                    begin
                        mem_re   = 1'b1;
                        mem_addr = cell_addr(rd_phys, COL_W'(item_reg.read_col));
                    end
                end
                else if (is_lf || is_cr)
                    cur_col_next = '0;
                else
                begin
                    mem_we       = 1'b1;
                    mem_addr     = cell_addr(cur_phys, cur_col_reg);
                    mem_wdata    = {cfg.text_color, item_reg.char_code};
                    cur_col_next = last_col ? '0 : cur_col_reg + 1'b1;
                end
                if (advance)
                begin
                    if (last_row)
                    begin
                        // Ring scroll: old top row becomes the new bottom row
                        base_next      = row_wrap(base_reg, ROW_W'(1));
                        blank_row_next = base_reg;
                        blank_col_next = '0;
                        scrolled_next  = 1'b1;
                    end
                    else
                        cur_row_next = cur_row_reg + 1'b1;
                end
            end
            ST_READ:
                cell_next = mem_rdata;
            ST_BLANK:
            begin
                mem_we         = 1'b1;
                mem_addr       = cell_addr(blank_row_reg, blank_col_reg);
                mem_wdata      = {cfg.text_color, CH_BLANK};
                blank_col_next = blank_col_reg + 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_cell_next  = cell_reg;
                    rsp_row_next   = ROW_FIELD_W'(cur_row_reg);
                    rsp_col_next   = COL_FIELD_W'(cur_col_reg);
                    rsp_scr_next   = scrolled_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            base_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            base_reg      <= base_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        blank_row_reg <= blank_row_next;
        blank_col_reg <= blank_col_next;
        cell_reg      <= cell_next;
        scrolled_reg  <= scrolled_next;
        rsp_cell_reg  <= rsp_cell_next;
        rsp_row_reg   <= rsp_row_next;
        rsp_col_reg   <= rsp_col_next;
        rsp_scr_reg   <= rsp_scr_next;
    end

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cell_value = rsp_cell_reg;
    assign rsp.cursor_row = rsp_row_reg;
    assign rsp.cursor_col = rsp_col_reg;
    assign rsp.scrolled   = rsp_scr_reg;

endmodule

[rtl/text_console_cursor_scroll.sv]
// Top level of the text console engine: config registers and console core.
//
// Usage:
//  - cmd channel (valid/ready): one word per character put (op 0) or cell read
//    (op 1). rsp channel (valid/ready): exactly one word per cmd word, in order,
//    carrying the read cell (0 for puts), the cursor after the word and a
//    scroll flag.
//  - APB port: register 0 at byte address 0 is text_color (attribute byte),
//    reset 0x07. Write it only while no word is in flight.
//  - A put passes EXEC, then RESP, where the result is registered; a read
//    adds READ, and a word that scrolls adds BLANK, before RESP. One word is
//    worked on at a time; the next is taken the cycle after the result is
//    registered. The single-port RAM sets the pace.
//  - Scrolling moves a ring base row pointer, so only the new bottom row is
//    rewritten (one cell per cycle), not the whole screen.
//  - Reset: cursor to 0,0 and a clearing pass writes 0x0720 into all
//    ROWS*COLUMNS cells; cmd.ready stays low until it finishes.
//  - Back-pressure: the result sits in an output register; the next word is
//    still accepted and worked on, and waits only when its own result is ready
//    while the previous one has not been taken.
`timescale 1ns / 1ps

module text_console_cursor_scroll import tccs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    tccs_cmd_if.sink              cmd,
    tccs_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;

    // Register file: text color only
    tccs_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer around the screen RAM
    tccs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .rsp   (rsp)
    );

endmodule

[rtl/tccs_checker.sv]
// Port-level checker for the text console engine, bound to the top level.
`timescale 1ns / 1ps

module tccs_checker import tccs_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cmd_valid,
    input logic                   cmd_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [CELL_W-1:0]      rsp_cell_value,
    input logic [ROW_FIELD_W-1:0] rsp_cursor_row,
    input logic [COL_FIELD_W-1:0] rsp_cursor_col,
    input logic                   rsp_scrolled
);

    logic [1:0] pending_reg, pending_next;
    logic       cmd_acc, rsp_acc;

    assign cmd_acc = cmd_valid && cmd_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(cmd_acc) - 2'(rsp_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result holds its word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value)
            && $stable(rsp_cursor_row) && $stable(rsp_cursor_col) && $stable(rsp_scrolled))
        else $error("rsp word changed while stalled");

    // No result without an outstanding command
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("rsp word without matching cmd word");

    // At most one word in work plus one in the output register
    a_pending_max: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many cmd words outstanding");

    // A scroll leaves the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_scrolled |-> int'(rsp_cursor_row) == ROWS - 1
            && rsp_cursor_col == '0)
        else $error("scroll with cursor off the last row start");

    // Clearing pass holds off commands right after reset
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !cmd_ready)
        else $error("cmd accepted before screen clear");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_cell_value (rsp.cell_value),
    .rsp_cursor_row (rsp.cursor_row),
    .rsp_cursor_col (rsp.cursor_col),
    .rsp_scrolled   (rsp.scrolled)
);
